@@ sv/hbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants for the huffman bit packing encoder.
// ----------------------------------------------------------------------------
package hbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int SYM_W        = 8;
   localparam int NUM_SYMBOLS  = 1 << SYM_W;
   localparam int CODE_LIM     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int ACC_W        = CODE_W + 8;

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2
   } req_code_type;

   typedef struct packed {
      logic              is_flush;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } hbp_item_type;

endpackage

@@ sv/huffman_bit_packing_encoder.sv @@
// path: an encode or flush result passes the table read register, the queue and the
//   response register; a full queue or a stalled response can hold it on the way
// intake: one request per cycle while req_stall is low (it rises when the queue is full);
//   the packer emits one byte per cycle while not stalled, and an encode yields at most 4 bytes
// table writes complete in the accepting cycle; a 4-entry queue decouples intake and packer
// reset: synchronous, clears table valid bits, pending bits, queue and response at once
// ----------------------------------------------------------------------------
// huffman_bit_packing_encoder
// Huffman encoder with loaded code table and byte-wise bit packing.
// ----------------------------------------------------------------------------
module huffman_bit_packing_encoder import hbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic [CODE_W-1:0] req_code_bits,
   input  logic [LEN_W-1:0]  req_code_len,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic [2:0]        rsp_pad_bits,
   output logic              rsp_last_of_run
);

   logic         push;
   hbp_item_type push_item;
   logic         queue_full;
   logic         pop;
   logic         head_valid;
   hbp_item_type head_item;

   hbp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_symbol    (req_symbol),
      .req_code_bits (req_code_bits),
      .req_code_len  (req_code_len),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   hbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   hbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_pad_bits    (rsp_pad_bits),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ sv/hbp_front.sv @@
// ----------------------------------------------------------------------------
// hbp_front
// Request intake: code table with valid bits, table read and code masking,
// hands encode and flush work to the queue.
// ----------------------------------------------------------------------------
module hbp_front import hbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic [CODE_W-1:0] req_code_bits,
   input  logic [LEN_W-1:0]  req_code_len,
   input  logic              queue_full,
   output logic              push,
   output hbp_item_type      push_item
);

   logic [LEN_W+CODE_W-1:0] table_mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0]  entry_valid_ff;
   logic [LEN_W+CODE_W-1:0] rd_entry_ff;
   logic                    rd_hit_ff;
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic                    s1_flush_ff;
   logic                    accept;
   logic                    is_write;
   logic                    is_encode;
   logic                    is_flush;
   logic [LEN_W-1:0]        wr_len;
   logic [LEN_W-1:0]        len_eff;
   logic [CODE_W:0]         mask_wide;
   logic                    push_wanted;

   assign accept    = req_valid && !req_stall;
   assign is_write  = (req_type == REQ_WRITE);
   assign is_encode = (req_type == REQ_ENCODE);
   assign is_flush  = (req_type == REQ_FLUSH);
   assign wr_len    = (req_code_len > LEN_W'(CODE_LIM)) ? LEN_W'(CODE_LIM) : req_code_len;

   assign len_eff     = rd_hit_ff ? rd_entry_ff[LEN_W+CODE_W-1:CODE_W] : '0;
   assign mask_wide   = ((CODE_W+1)'(1) << len_eff) - (CODE_W+1)'(1);
   assign push_wanted = s1_valid_ff && (s1_flush_ff || (len_eff != '0));
   assign push        = push_wanted && !queue_full;
   assign req_stall   = push_wanted && queue_full;

   assign push_item.is_flush = s1_flush_ff;
   assign push_item.code     = rd_entry_ff[CODE_W-1:0] & mask_wide[CODE_W-1:0];
   assign push_item.len      = s1_flush_ff ? '0 : len_eff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = is_encode || is_flush;
      end else if (!req_stall) begin
         s1_valid_in = 1'b0;
      end
   end

   // table storage, table read and stage flush flag
   always_ff @(posedge clock) begin
      if (accept && is_write) begin
         table_mem[req_symbol] <= {wr_len, req_code_bits};
      end
      if (accept && is_encode) begin
         rd_entry_ff <= table_mem[req_symbol];
         rd_hit_ff   <= entry_valid_ff[req_symbol];
      end
      if (accept) begin
         s1_flush_ff <= is_flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept && is_write) begin
            entry_valid_ff[req_symbol] <= 1'b1;
         end
      end
   end

endmodule

@@ sv/hbp_queue.sv @@
// ----------------------------------------------------------------------------
// hbp_queue
// Short work queue between intake and bit packer.
// ----------------------------------------------------------------------------
module hbp_queue import hbp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hbp_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output hbp_item_type head_item
);

   hbp_item_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule

@@ sv/hbp_back.sv @@
// ----------------------------------------------------------------------------
// hbp_back
// Bit packer: merges codes with pending bits, emits one byte per cycle while the
// response is not stalled, handles flush, holds the response register.
// ----------------------------------------------------------------------------
module hbp_back import hbp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  hbp_item_type head_item,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_byte_valid,
   output logic [2:0]   rsp_pad_bits,
   output logic         rsp_last_of_run
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic [6:0]        pend_ff, pend_in;
   logic [2:0]        pcount_ff, pcount_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              bvalid_ff, bvalid_in;
   logic [2:0]        pad_ff, pad_in;
   logic              last_ff, last_in;

   logic              out_free;
   logic [CODE_W-1:0] code_left;
   logic [ACC_W-1:0]  new_acc;
   logic [LEN_W-1:0]  new_total;
   logic [ACC_W-1:0]  cur_acc;
   logic [LEN_W-1:0]  cur_total;
   logic [ACC_W-1:0]  shifted;
   logic [LEN_W-1:0]  rem;
   logic              emit_enc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign code_left = head_item.code << (LEN_W'(CODE_W) - head_item.len);
   assign new_acc   = {pend_ff, (ACC_W-7)'(0)} | ({code_left, 8'd0} >> pcount_ff);
   assign new_total = LEN_W'(pcount_ff) + head_item.len;
   assign cur_acc   = (state_ff == ST_EMIT) ? acc_ff : new_acc;
   assign cur_total = (state_ff == ST_EMIT) ? total_ff : new_total;
   assign shifted   = cur_acc << 8;
   assign rem       = cur_total - LEN_W'(8);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      pend_in      = pend_ff;
      pcount_in    = pcount_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_in      = byte_ff;
      bvalid_in    = bvalid_ff;
      pad_in       = pad_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      emit_enc     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_item.is_flush) begin
                  if (out_free) begin
                     pop          = 1'b1;
                     rsp_valid_in = 1'b1;
                     byte_in      = {pend_ff, 1'b0};
                     bvalid_in    = (pcount_ff != '0);
                     pad_in       = (pcount_ff == '0) ? 3'd0 : 3'(4'd8 - {1'b0, pcount_ff});
                     last_in      = 1'b1;
                     pend_in      = '0;
                     pcount_in    = '0;
                  end
               end else if (new_total < LEN_W'(8)) begin
                  pop       = 1'b1;
                  pend_in   = new_acc[ACC_W-1 -: 7];
                  pcount_in = new_total[2:0];
               end else if (out_free) begin
                  pop      = 1'b1;
                  emit_enc = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            emit_enc = out_free;
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit_enc) begin
         rsp_valid_in = 1'b1;
         byte_in      = cur_acc[ACC_W-1 -: 8];
         bvalid_in    = 1'b1;
         pad_in       = 3'd0;
         last_in      = (rem < LEN_W'(8));
         if (rem < LEN_W'(8)) begin
            state_in  = ST_IDLE;
            pend_in   = shifted[ACC_W-1 -: 7];
            pcount_in = rem[2:0];
         end else begin
            state_in = ST_EMIT;
            acc_in   = shifted;
            total_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         pcount_ff    <= pcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff   <= acc_in;
      total_ff <= total_in;
      byte_ff  <= byte_in;
      bvalid_ff <= bvalid_in;
      pad_ff   <= pad_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_pad_bits    = pad_ff;
   assign rsp_last_of_run = last_ff;

endmodule

@@ sv/hbp_checker.sv @@
// ----------------------------------------------------------------------------
// hbp_checker
// Port-level checks on the response channel of the encoder.
// ----------------------------------------------------------------------------
module hbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic [2:0] rsp_pad_bits,
   input logic       rsp_last_of_run
);

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && rsp_stall && !reset) |-> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_pad_bits) && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // empty flush carries nothing
   a_empty_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last_of_run && rsp_pad_bits == 3'd0
         && rsp_out_byte == 8'd0)
      else $error("empty flush malformed");

   // padded byte ends its run and has zero pad bit
   a_pad_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pad_bits != 3'd0 |-> rsp_last_of_run && rsp_byte_valid
         && !rsp_out_byte[0])
      else $error("padded byte malformed");

   // no response straight after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind huffman_bit_packing_encoder hbp_checker u_hbp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_pad_bits    (rsp_pad_bits),
   .rsp_last_of_run (rsp_last_of_run)
);
